/* design/ring_nearest_set_cell_search_core_macros.svh */
// Assertion macros for the ring nearest set cell search core.
// Expects a clock named clk and an active-high reset named rst in the using module.
`ifndef RING_NEAREST_SET_CELL_SEARCH_CORE_MACROS_SVH
`define RING_NEAREST_SET_CELL_SEARCH_CORE_MACROS_SVH

// Same-cycle implication.
`define RNSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RNSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rnsc_pkg.sv */
// Package for the ring nearest set cell search core.
// Grid limits, field widths, opcodes and register indexes; no dependencies.
package rnsc_pkg;

  localparam int GRID_MAX_W = 256;
  localparam int GRID_MAX_H = 256;
  localparam int MEM_DEPTH  = GRID_MAX_W * GRID_MAX_H;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);

  localparam int CFG_W    = 9;   // grid_width / grid_height register width
  localparam int COORD_W  = 8;   // cell_col / cell_row field width
  localparam int AMOUNT_W = 16;
  localparam int POS_W    = 11;  // signed probe coordinate, origin +/- radius
  localparam int RAD_W    = POS_W - 1;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(256);

endpackage

/* design/rnsc_stream_if.sv */
// Valid/ready channel interfaces for items and results of the search core.
// Depends on rnsc_pkg for field widths.
interface rnsc_item_if
  import rnsc_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [COORD_W-1:0]         cell_col;
  logic [COORD_W-1:0]         cell_row;
  logic signed [AMOUNT_W-1:0] amount;

  modport source (output valid, opcode, cell_col, cell_row, amount, input ready);
  modport sink   (input valid, opcode, cell_col, cell_row, amount, output ready);
endinterface

interface rnsc_result_if
  import rnsc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               found;
  logic [COORD_W-1:0] found_col;
  logic [COORD_W-1:0] found_row;

  modport source (output valid, found, found_col, found_row, input ready);
  modport sink   (input valid, found, found_col, found_row, output ready);
endinterface

/* design/ring_nearest_set_cell_search_core.sv */
// Top level of the ring nearest set cell search core: mark memory, ring-scan sequencer,
// APB register port and result register. Depends on rnsc_pkg, rnsc_stream_if and the macros.
//
// After reset the block runs a clearing pass over the mark memory, one cell per cycle,
// and takes no items until it is done; register writes are taken meanwhile.
// A write item is stored as it is taken. A query probes one ring position per cycle through
// the single read port of the mark memory: radius 0 upward, each ring row by row from the top,
// left to right. A ring row lying wholly outside the grid is passed over whole; every other
// position on the ring is visited in turn. The scan stops at the first marked cell found.
// One item is worked on at a time; a finished result sits in an output register so that the
// next item is taken while it waits.
`include "ring_nearest_set_cell_search_core_macros.svh"

module ring_nearest_set_cell_search_core
  import rnsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  rnsc_item_if.sink          items,
  rnsc_result_if.source      results
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_HOLD} state_t;

  state_t state;

  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;

  logic [ADDR_W-1:0]  clr_addr;
  logic [COORD_W-1:0] org_col;
  logic [COORD_W-1:0] org_row;
  logic [RAD_W-1:0]   rad;
  logic signed [POS_W-1:0] dy;
  logic signed [POS_W-1:0] dx;
  logic               seq_done;

  logic               pend_valid;
  logic [COORD_W-1:0] pend_x;
  logic [COORD_W-1:0] pend_y;

  logic               res_found;
  logic [COORD_W-1:0] res_col;
  logic [COORD_W-1:0] res_row;

  logic               out_valid;
  logic               out_found;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;

  logic cell_marks [MEM_DEPTH];
  logic rd_data;

  // ---------------------------------------------------------------- config
  logic apb_wr;
  assign apb_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width);
      REG_GRID_HEIGHT: prdata = PDATA_W'(grid_height);
      default:         prdata = '0;
    endcase
  end

  logic [CFG_W-1:0] eff_w;
  logic [CFG_W-1:0] eff_h;
  logic [CFG_W-1:0] maxr;
  logic             grid_empty;

  assign eff_w = (grid_width > CFG_W'(GRID_MAX_W)) ? CFG_W'(GRID_MAX_W) : grid_width;
  assign eff_h = (grid_height > CFG_W'(GRID_MAX_H)) ? CFG_W'(GRID_MAX_H) : grid_height;
  assign maxr  = (eff_w > eff_h) ? eff_w : eff_h;
  assign grid_empty = (eff_w == '0) || (eff_h == '0);

  // ---------------------------------------------------------------- item side
  logic item_xfer;
  logic query_xfer;
  logic wr_in_grid;
  logic wr_mark;

  assign items.ready = (state == S_IDLE);
  assign item_xfer   = items.valid && items.ready;
  assign query_xfer  = item_xfer && (items.opcode == OP_QUERY);
  assign wr_in_grid  = (CFG_W'(items.cell_col) < eff_w) && (CFG_W'(items.cell_row) < eff_h);
  assign wr_mark     = (items.amount > 0);

  // ---------------------------------------------------------------- probe position
  logic signed [POS_W-1:0] rad_s;
  logic signed [POS_W-1:0] px;
  logic signed [POS_W-1:0] py;
  logic                    in_row;
  logic                    in_col;
  logic                    probe_ok;
  logic [ADDR_W-1:0]       probe_addr;

  assign rad_s  = $signed({1'b0, rad});
  assign px     = $signed(POS_W'(org_col)) + dx;
  assign py     = $signed(POS_W'(org_row)) + dy;
  assign in_row = !py[POS_W-1] && (py < $signed(POS_W'(eff_h)));
  assign in_col = !px[POS_W-1] && (px < $signed(POS_W'(eff_w)));
  assign probe_ok   = in_row && in_col;
  assign probe_addr = ADDR_W'(py) * ADDR_W'(GRID_MAX_W) + ADDR_W'(px);

  // ---------------------------------------------------------------- ring walk
  logic                    edge_row;
  logic                    row_last;
  logic [RAD_W-1:0]        rad_inc;
  logic [RAD_W-1:0]        rad_next;
  logic signed [POS_W-1:0] dy_next;
  logic signed [POS_W-1:0] dx_next;
  logic                    done_next;

  assign edge_row = (dy == -rad_s) || (dy == rad_s);
  // rows off the grid are skipped whole; side rows only have their two end cells
  assign row_last = !in_row || (edge_row ? (dx == rad_s) : (dx != -rad_s));
  assign rad_inc  = rad + RAD_W'(1);

  always_comb begin
    rad_next  = rad;
    dy_next   = dy;
    dx_next   = dx;
    done_next = 1'b0;
    if (!row_last) begin
      dx_next = edge_row ? dx + POS_W'(1) : rad_s;
    end else if (dy != rad_s) begin
      dy_next = dy + POS_W'(1);
      dx_next = -rad_s;
    end else begin
      rad_next  = rad_inc;
      dy_next   = -$signed({1'b0, rad_inc});
      dx_next   = -$signed({1'b0, rad_inc});
      done_next = (rad_inc > RAD_W'(maxr));
    end
  end

  // ---------------------------------------------------------------- mark memory
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_wdata;
  logic              mem_re;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 1'b0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (item_xfer && items.opcode == OP_WRITE && wr_in_grid) begin
      mem_we    = 1'b1;
      mem_waddr = ADDR_W'(items.cell_row) * ADDR_W'(GRID_MAX_W) + ADDR_W'(items.cell_col);
      mem_wdata = wr_mark;
    end
  end

  assign mem_re = (state == S_SCAN) && !seq_done && probe_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_marks[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= cell_marks[probe_addr];
    end
  end

  // ---------------------------------------------------------------- control
  logic hit;
  logic out_free;

  assign hit      = pend_valid && rd_data;
  assign out_free = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      grid_width  <= DIM_RESET;
      grid_height <= DIM_RESET;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
      seq_done    <= 1'b0;
    end else begin
      if (apb_wr) begin
        case (paddr[2])
          REG_GRID_WIDTH:  grid_width  <= pwdata[CFG_W-1:0];
          REG_GRID_HEIGHT: grid_height <= pwdata[CFG_W-1:0];
          default: ;
        endcase
      end

      if (state == S_HOLD && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (query_xfer) begin
            org_col    <= items.cell_col;
            org_row    <= items.cell_row;
            rad        <= '0;
            dy         <= '0;
            dx         <= '0;
            seq_done   <= 1'b0;
            pend_valid <= 1'b0;
            res_found  <= 1'b0;
            res_col    <= '0;
            res_row    <= '0;
            state      <= grid_empty ? S_HOLD : S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_found  <= 1'b1;
            res_col    <= pend_x;
            res_row    <= pend_y;
            pend_valid <= 1'b0;
            state      <= S_HOLD;
          end else if (seq_done && !pend_valid) begin
            state <= S_HOLD;
          end else if (seq_done) begin
            pend_valid <= 1'b0;
          end else begin
            pend_valid <= probe_ok;
            pend_x     <= px[COORD_W-1:0];
            pend_y     <= py[COORD_W-1:0];
            rad        <= rad_next;
            dy         <= dy_next;
            dx         <= dx_next;
            seq_done   <= done_next;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_found <= res_found;
            out_col   <= res_col;
            out_row   <= res_row;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid     = out_valid;
  assign results.found     = out_found;
  assign results.found_col = out_col;
  assign results.found_row = out_row;

  // ---------------------------------------------------------------- checks
  logic pend_in_grid;
  logic miss_coords_zero;

  assign pend_in_grid     = (CFG_W'(pend_x) < eff_w) && (CFG_W'(pend_y) < eff_h);
  assign miss_coords_zero = (results.found_col == '0) && (results.found_row == '0);

  `RNSC_ASSERT_NOW(a_pend_from_scan, pend_valid, $past(state) == S_SCAN, "probe pending outside scan")
  `RNSC_ASSERT_NOW(a_pend_in_grid, pend_valid, pend_in_grid, "probe outside grid")
  `RNSC_ASSERT_NOW(a_miss_zero, results.valid && !results.found, miss_coords_zero, "miss nonzero")
  `RNSC_ASSERT_NEXT(a_query_leaves_idle, query_xfer, state != S_IDLE, "query did not start")

endmodule

/* dv/ring_nearest_set_cell_search_core_test.sv */
// Self-checking testbench for ring_nearest_set_cell_search_core: writes marks, runs ring queries
// and compares every result with a ring-scan predictor kept in a scoreboard class.
// Depends on rnsc_pkg, the rnsc_item_if / rnsc_result_if interfaces and the core itself.
module ring_nearest_set_cell_search_core_test
  import rnsc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int SETTLE_TICKS = 8;
  localparam int TAIL_TICKS   = 32;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } cell_hit_t;

  class nearest_cell_scoreboard;
    bit               marks [GRID_MAX_W*GRID_MAX_H];
    logic [CFG_W-1:0] grid_w;
    logic [CFG_W-1:0] grid_h;
    cell_hit_t        pending_hits[$];
    int               errors;

    function new();
      grid_w = DIM_RESET;
      grid_h = DIM_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [PDATA_W-1:0] value);
      if (idx == REG_GRID_WIDTH) grid_w = value[CFG_W-1:0];
      else grid_h = value[CFG_W-1:0];
    endfunction

    function bit marked(int x, int y, int w, int h);
      if (x < 0 || y < 0 || x >= w || y >= h) return 1'b0;
      return marks[y*GRID_MAX_W + x];
    endfunction

    // Square rings of growing radius, each ring top row to bottom row, left to right.
    function cell_hit_t nearest_mark(int col, int row);
      int w, h, maxr, y;
      cell_hit_t hit;
      w = (grid_w > GRID_MAX_W) ? GRID_MAX_W : int'(grid_w);
      h = (grid_h > GRID_MAX_H) ? GRID_MAX_H : int'(grid_h);
      hit = '0;
      if (w == 0 || h == 0) return hit;
      maxr = (w > h) ? w : h;
      for (int rad = 0; rad <= maxr; rad++) begin
        for (int dy = -rad; dy <= rad; dy++) begin
          y = row + dy;
          if (y < 0 || y >= h) continue;
          if (dy == -rad || dy == rad) begin
            for (int dx = -rad; dx <= rad; dx++)
              if (marked(col + dx, y, w, h)) return '{1'b1, COORD_W'(col + dx), COORD_W'(y)};
          end else begin
            if (marked(col - rad, y, w, h)) return '{1'b1, COORD_W'(col - rad), COORD_W'(y)};
            if (marked(col + rad, y, w, h)) return '{1'b1, COORD_W'(col + rad), COORD_W'(y)};
          end
        end
      end
      return hit;
    endfunction

    function void note_item(logic op, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                            logic [AMOUNT_W-1:0] amt);
      int w, h;
      w = (grid_w > GRID_MAX_W) ? GRID_MAX_W : int'(grid_w);
      h = (grid_h > GRID_MAX_H) ? GRID_MAX_H : int'(grid_h);
      if (op == OP_WRITE) begin
        if (int'(col) < w && int'(row) < h)
          marks[int'(row)*GRID_MAX_W + int'(col)] = ($signed(amt) > 0);
      end else begin
        pending_hits = {pending_hits, nearest_mark(int'(col), int'(row))};
      end
    endfunction

    function void check_result(logic found, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
      cell_hit_t exp_hit;
      if (pending_hits.size() == 0) begin
        $display("%0t: result with no query pending: found=%0d col=%0d row=%0d",
                 $time, found, col, row);
        errors++;
        return;
      end
      exp_hit = pending_hits.pop_front();
      if (found !== exp_hit.found) begin
        $display("%0t: found mismatch, expected %0d actual %0d", $time, exp_hit.found, found);
        errors++;
      end
      if (col !== exp_hit.col) begin
        $display("%0t: found_col mismatch, expected %0d actual %0d", $time, exp_hit.col, col);
        errors++;
      end
      if (row !== exp_hit.row) begin
        $display("%0t: found_row mismatch, expected %0d actual %0d", $time, exp_hit.row, row);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  rnsc_item_if   item_ch ();
  rnsc_result_if result_ch ();

  ring_nearest_set_cell_search_core u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .items   (item_ch),
    .results (result_ch)
  );

  nearest_cell_scoreboard sb;
  int send_idle;
  int recv_stall;
  int cur_w;
  int cur_h;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // Result side: check each transfer, then pick the next ready at random.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.found, result_ch.found_col, result_ch.found_row);
      result_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic push_item(logic op, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                           logic [AMOUNT_W-1:0] amt);
    while ($urandom_range(99) < send_idle) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid    <= 1'b1;
    item_ch.opcode   <= op;
    item_ch.cell_col <= col;
    item_ch.cell_row <= row;
    item_ch.amount   <= amt;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(op, col, row, amt);
  endtask

  // Stop sending and wait until every query has answered, then let the core settle.
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic apb_write(logic idx, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic set_grid(logic [PDATA_W-1:0] w, logic [PDATA_W-1:0] h);
    drain_results();
    apb_write(REG_GRID_WIDTH, w);
    apb_write(REG_GRID_HEIGHT, h);
    cur_w = (int'(w[CFG_W-1:0]) > GRID_MAX_W) ? GRID_MAX_W : int'(w[CFG_W-1:0]);
    cur_h = (int'(h[CFG_W-1:0]) > GRID_MAX_H) ? GRID_MAX_H : int'(h[CFG_W-1:0]);
  endtask

  // Small grids keep a missed query short; zero now and then for the empty grid.
  function automatic int pick_dim();
    if ($urandom_range(15) == 0) return 0;
    return $urandom_range(16, 1);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(int limit);
    if (limit == 0 || $urandom_range(9) >= 8) return COORD_W'($urandom_range(255));
    return COORD_W'($urandom_range(limit - 1));
  endfunction

  task automatic random_item();
    logic                op;
    logic [AMOUNT_W-1:0] amt;
    op = ($urandom_range(99) < 45) ? OP_QUERY : OP_WRITE;
    case ($urandom_range(3))
      0, 1: amt = AMOUNT_W'($urandom_range(32767, 1));
      2:    amt = AMOUNT_W'($urandom);
      default: amt = $urandom_range(1) ? '0 : {1'b1, 15'($urandom)};
    endcase
    push_item(op, pick_coord(cur_w), pick_coord(cur_h), amt);
  endtask

  task automatic run_phase(int s_idle, int r_stall, int n, bit hold_mid);
    send_idle  = s_idle;
    recv_stall = r_stall;
    set_grid(pick_dim(), pick_dim());
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) begin
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending_hits.size() != 0);
      end
      random_item();
    end
  endtask

  initial begin
    item_ch.valid    = 1'b0;
    item_ch.opcode   = OP_WRITE;
    item_ch.cell_col = '0;
    item_ch.cell_row = '0;
    item_ch.amount   = '0;
    result_ch.ready  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    send_idle  = 0;
    recv_stall = 0;
    cur_w = GRID_MAX_W;
    cur_h = GRID_MAX_H;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full grid from reset: corners, most negative amount, tie order within a ring.
    push_item(OP_WRITE, 8'd0, 8'd0, 16'h0001);
    push_item(OP_WRITE, 8'd255, 8'd255, 16'h7FFF);
    push_item(OP_WRITE, 8'd40, 8'd40, 16'h8000);
    push_item(OP_QUERY, 8'd0, 8'd0, 16'h0000);
    push_item(OP_QUERY, 8'd255, 8'd255, 16'h0000);
    push_item(OP_QUERY, 8'd3, 8'd2, 16'hFFFF);
    push_item(OP_WRITE, 8'd100, 8'd50, 16'h0005);
    push_item(OP_WRITE, 8'd102, 8'd50, 16'h0007);
    push_item(OP_QUERY, 8'd101, 8'd50, 16'h0000);
    push_item(OP_WRITE, 8'd110, 8'd60, 16'h0001);
    push_item(OP_WRITE, 8'd112, 8'd62, 16'h0001);
    push_item(OP_QUERY, 8'd111, 8'd61, 16'h0000);
    push_item(OP_WRITE, 8'd255, 8'd255, 16'h0000);
    push_item(OP_QUERY, 8'd255, 8'd255, 16'h0000);

    // Small grid: writes past the edge, query from far outside, query amount ignored.
    // Upper bits of the width write lie beyond the register.
    set_grid(32'hABCD_E008, 32'd5);
    push_item(OP_WRITE, 8'd10, 8'd2, 16'h0009);
    push_item(OP_WRITE, 8'd7, 8'd4, 16'h0003);
    push_item(OP_WRITE, 8'd3, 8'd5, 16'h0003);
    push_item(OP_QUERY, 8'd0, 8'd0, 16'h0000);
    push_item(OP_QUERY, 8'd200, 8'd200, 16'h0000);
    push_item(OP_QUERY, 8'd2, 8'd2, 16'h7FFF);

    set_grid(32'd0, 32'd5);
    push_item(OP_QUERY, 8'd0, 8'd0, 16'h0000);
    push_item(OP_WRITE, 8'd1, 8'd1, 16'h0001);

    // Width above the limit clamps to the full grid.
    set_grid(32'd511, 32'd256);
    push_item(OP_WRITE, 8'd250, 8'd0, 16'h0002);
    push_item(OP_QUERY, 8'd255, 8'd0, 16'h0000);

    set_grid(32'd16, 32'd0);
    push_item(OP_QUERY, 8'd4, 8'd4, 16'h0000);

    // Grid grows over the earlier ignored write: it must still read as clear.
    set_grid(32'd16, 32'd16);
    push_item(OP_QUERY, 8'd10, 8'd3, 16'h0000);

    run_phase(0, 0, 25, 1'b0);
    run_phase(74, 0, 25, 1'b1);
    run_phase(0, 74, 25, 1'b0);
    run_phase(34, 34, 25, 1'b0);

    item_ch.valid <= 1'b0;
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (TAIL_TICKS) @(posedge clk);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
